/* design/nau_pkg.sv */
// ----------------------------------------------------------------------------
// nau_pkg
// Shared types and constants of the neural activation unit: activation mode
// codes, configuration register indexes and reset values, and the control
// word that travels down the pipeline beside the data.
// ----------------------------------------------------------------------------
package nau_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int MODE_W     = 3;
	localparam int SLOPE_W    = 12;

	typedef enum logic [MODE_W-1:0] {
		MODE_RELU     = 3'd0,
		MODE_LEAKY    = 3'd1,
		MODE_STEP     = 3'd2,
		MODE_SIGMOID  = 3'd3,
		MODE_TANH     = 3'd4,
		MODE_SWISH    = 3'd5,
		MODE_IDENTITY = 3'd6
	} act_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACT_MODE     = 2'd0,
		CFG_CLAMP_ENABLE = 2'd1,
		CFG_LEAKY_SLOPE  = 2'd2
	} cfg_reg_t;

	localparam logic [MODE_W-1:0]  ACT_MODE_RST    = 3'd6;
	localparam logic               CLAMP_RST       = 1'b0;
	localparam logic [SLOPE_W-1:0] LEAKY_SLOPE_RST = 12'd410;

	// Control word carried with every item
	typedef struct packed {
		logic                valid;
		logic                last;
		logic [MODE_W-1:0]   mode;
		logic                clamp;
	} nau_ctrl_t;

endpackage

/* design/neural_activation_unit.sv */
// ----------------------------------------------------------------------------
// neural_activation_unit
// Per-sample activation (ReLU, leaky ReLU, step, sigmoid, tanh, swish,
// identity) on signed fixed-point data, four register stages deep.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive sample and last_in and raise start; the item is
//   taken at the rising edge where start is high and busy is low. busy is
//   always low, so a new item can be taken in every cycle.
//   Result channel: done is high for exactly one cycle per item, with
//   activation and last_out valid in that cycle. Results leave in the order
//   the items came in. The receiver cannot stall, so nothing is held back.
//   Throughput is one item per cycle, set by the fully pipelined datapath:
//   stage 1 forms the sigmoid magnitude, stage 2 the PLAN sigmoid and the
//   leaky product, stage 3 the swish product and mode selection, stage 4
//   scaling, saturation and clamp.
//   Configuration: cfg_we with cfg_index/cfg_wdata writes act_mode (0),
//   clamp_enable (1) or leaky_slope (2); index 3 is dropped. Write only when
//   no item is in flight.
//   Reset: arst_n clears the stage valid bits and loads act_mode = identity,
//   clamp off and leaky_slope = 410 (about 0.1). No clearing pass follows.
// ----------------------------------------------------------------------------
module neural_activation_unit import nau_pkg::*; #(
	parameter int FRAC_BITS  = 12,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] sample,
	input  logic                         last_in,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] activation,
	output logic                         last_out
);

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int MW  = W + 1;                            // |x| or |2x|
	localparam int YW  = ((W > F + 2) ? W : F + 2) + 1;    // pre-saturation result
	localparam int LPW = W + SLOPE_W + 1;                  // leaky product
	localparam int SPW = W + F + 2;                        // swish product
	localparam logic signed [YW-1:0] ONE_Y = YW'(64'sd1 <<< F);

	// configuration registers
	logic [MODE_W-1:0]  act_mode_q;
	logic               clamp_enable_q;
	logic [SLOPE_W-1:0] leaky_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q     <= ACT_MODE_RST;
			clamp_enable_q <= CLAMP_RST;
			leaky_slope_q  <= LEAKY_SLOPE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ACT_MODE:     act_mode_q     <= cfg_wdata[MODE_W-1:0];
				CFG_CLAMP_ENABLE: clamp_enable_q <= cfg_wdata[0];
				CFG_LEAKY_SLOPE:  leaky_slope_q  <= cfg_wdata[SLOPE_W-1:0];
				default: ;        // drop writes to unused indexes
			endcase
		end
	end

	assign busy = 1'b0;

	// ---------------- stage 1: capture, form sigmoid argument ----------------
	logic signed [MW-1:0] arg_c;
	logic                 neg_c;
	logic [MW-1:0]        mag_c;

	always_comb begin
		// tanh evaluates the sigmoid at 2x, kept at full precision
		if (act_mode_t'(act_mode_q) == MODE_TANH) begin
			arg_c = {sample, 1'b0};
		end else begin
			arg_c = MW'(sample);
		end
		neg_c = arg_c[MW-1];
		mag_c = neg_c ? MW'(-arg_c) : MW'(arg_c);
	end

	nau_ctrl_t           ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [W-1:0] x_s1, x_s2;
	logic [MW-1:0]       mag_s1;
	logic                neg_s1;

	// control words advance together; only the valid bits matter after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1.valid <= start && !busy;
			ctrl_s1.last  <= last_in;
			ctrl_s1.mode  <= act_mode_q;
			ctrl_s1.clamp <= clamp_enable_q;
			ctrl_s2       <= ctrl_s1;
			ctrl_s3       <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1          <= sample;
		mag_s1        <= mag_c;
		neg_s1        <= neg_c;
	end

	// ---------------- stage 2: PLAN sigmoid, leaky product ----------------
	logic [F:0]            sig_c, sig_s2;
	logic signed [LPW-1:0] lprod_c, lprod_s2;

	nau_sigmoid #(
		.FRAC_BITS (F),
		.MAG_W     (MW)
	) u_sigmoid (
		.mag (mag_s1),
		.neg (neg_s1),
		.sig (sig_c)
	);

	assign lprod_c = LPW'(x_s1) * LPW'($signed({1'b0, leaky_slope_q}));

	always_ff @(posedge clk) begin
		x_s2          <= x_s1;
		sig_s2        <= sig_c;
		lprod_s2      <= lprod_c;
	end

	// ---------------- stage 3: swish product, mode select ----------------
	logic signed [SPW-1:0] sprod_c, prod_s3;
	logic signed [YW-1:0]  y_c, y_s3;
	logic signed [YW-1:0]  x_y;

	assign sprod_c = SPW'(x_s2) * SPW'($signed({1'b0, sig_s2}));
	assign x_y     = YW'(x_s2);

	always_comb begin
		case (act_mode_t'(ctrl_s2.mode))
			MODE_RELU:    y_c = x_s2[W-1] ? '0 : x_y;
			// arithmetic shift floors the scaled negative side
			MODE_LEAKY:   y_c = x_s2[W-1] ? YW'(lprod_s2 >>> SLOPE_W) : x_y;
			MODE_STEP:    y_c = x_s2[W-1] ? '0 : ONE_Y;
			MODE_SIGMOID: y_c = YW'({1'b0, sig_s2});
			MODE_TANH:    y_c = YW'($signed({1'b0, sig_s2, 1'b0})) - ONE_Y;
			// swish is finished in the last stage from the product
			default:      y_c = x_y;
		endcase
	end

	always_ff @(posedge clk) begin
		y_s3          <= y_c;
		prod_s3       <= sprod_c;
	end

	// ---------------- stage 4: scale, saturate, clamp, output ----------------
	nau_post #(
		.FRAC_BITS  (F),
		.DATA_WIDTH (W)
	) u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s3    (ctrl_s3),
		.y_s3       (y_s3),
		.prod_s3    (prod_s3),
		.done       (done),
		.activation (activation),
		.last_out   (last_out)
	);

endmodule

/* design/nau_sigmoid.sv */
// ----------------------------------------------------------------------------
// nau_sigmoid
// Four-segment piecewise-linear sigmoid on a magnitude and sign, giving an
// unsigned result in [0, 1.0] with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module nau_sigmoid import nau_pkg::*; #(
	parameter int FRAC_BITS = 12,
	parameter int MAG_W     = 17
) (
	input  logic [MAG_W-1:0]   mag,
	input  logic               neg,
	output logic [FRAC_BITS:0] sig
);

	localparam int CW = (MAG_W > FRAC_BITS + 4) ? MAG_W : FRAC_BITS + 4;
	localparam logic [CW-1:0] ONE_C   = CW'(64'd1 << FRAC_BITS);
	localparam logic [CW-1:0] TH_SAT  = CW'(64'd5 << FRAC_BITS);
	localparam logic [CW-1:0] TH_MID  = CW'((64'd19 << FRAC_BITS) >> 3);
	localparam logic [CW-1:0] OFS_HI  = CW'((64'd27 << FRAC_BITS) >> 5);
	localparam logic [CW-1:0] OFS_MID = CW'((64'd5 << FRAC_BITS) >> 3);
	localparam logic [CW-1:0] OFS_LO  = CW'(64'd1 << (FRAC_BITS - 1));

	logic [CW-1:0] a;
	logic [CW-1:0] y;

	always_comb begin
		a = CW'(mag);
		if (a >= TH_SAT) begin
			y = ONE_C;
		end else if (a >= TH_MID) begin
			y = (a >> 5) + OFS_HI;
		end else if (a >= ONE_C) begin
			y = (a >> 3) + OFS_MID;
		end else begin
			y = (a >> 2) + OFS_LO;
		end
		// mirror about one half for negative arguments
		sig = neg ? (FRAC_BITS+1)'(ONE_C - y) : (FRAC_BITS+1)'(y);
	end

endmodule

/* design/nau_post.sv */
// ----------------------------------------------------------------------------
// nau_post
// Final stage: scale the swish product, saturate to the data range, apply
// the optional [-1, 1] clamp and register the result for its strobe cycle.
// ----------------------------------------------------------------------------
module nau_post import nau_pkg::*; #(
	parameter int FRAC_BITS  = 12,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  nau_ctrl_t                               ctrl_s3,
	input  logic signed [((DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2):0] y_s3,
	input  logic signed [DATA_WIDTH+FRAC_BITS+1:0]  prod_s3,
	output logic                                    done,
	output logic signed [DATA_WIDTH-1:0]            activation,
	output logic                                    last_out
);

	localparam int YW = ((DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2) + 1;
	localparam longint DMAX_L = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam longint DMIN_L = -DMAX_L - 64'sd1;
	localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [YW-1:0] DMAX_Y = YW'(DMAX_L);
	localparam logic signed [YW-1:0] DMIN_Y = YW'(DMIN_L);
	localparam logic signed [YW-1:0] HI_Y   = YW'((ONE_L > DMAX_L) ? DMAX_L : ONE_L);
	localparam logic signed [YW-1:0] LO_Y   = YW'((-ONE_L < DMIN_L) ? DMIN_L : -ONE_L);

	logic signed [YW-1:0] sel_c;
	logic signed [YW-1:0] sat_c;
	logic signed [YW-1:0] fin_c;

	always_comb begin
		sel_c = y_s3;
		if (act_mode_t'(ctrl_s3.mode) == MODE_SWISH) begin
			sel_c = YW'(prod_s3 >>> FRAC_BITS);
		end
		sat_c = sel_c;
		if (sel_c > DMAX_Y) begin
			sat_c = DMAX_Y;
		end else if (sel_c < DMIN_Y) begin
			sat_c = DMIN_Y;
		end
		fin_c = sat_c;
		if (ctrl_s3.clamp) begin
			if (sat_c > HI_Y) begin
				fin_c = HI_Y;
			end else if (sat_c < LO_Y) begin
				fin_c = LO_Y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		activation <= DATA_WIDTH'(fin_c);
		last_out   <= ctrl_s3.last;
	end

endmodule

/* design/nau_checker.sv */
// ----------------------------------------------------------------------------
// nau_checker
// Port-level checks of the activation unit: busy never raised, fixed
// latency, one result per item and the end mark following its item.
// ----------------------------------------------------------------------------
module nau_checker import nau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in,
	input logic done,
	input logic last_out
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("item produced no result after four edges");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without a matching item");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, 4)))
		else $error("last_out does not match its item");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.last_in  (last_in),
	.done     (done),
	.last_out (last_out)
);

/* tb/neural_activation_unit_checker.sv */
// ----------------------------------------------------------------------------
// neural_activation_unit_checker
// Watches the item, result and register ports of the activation unit. It
// tracks the registers, works out the activation of every accepted item and
// compares each result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module neural_activation_unit_checker import nau_pkg::*; #(
	parameter int FRAC_BITS  = 12,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] sample,
	input  logic                         last_in,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                         done,
	input  logic signed [DATA_WIDTH-1:0] activation,
	input  logic                         last_out,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
	localparam longint SAT_HI      = (longint'(1) << (DATA_WIDTH - 1)) - 1;
	localparam longint SAT_LO      = -SAT_HI - 1;
	localparam longint KNEE_FLAT   = 5 * ONE_Q;
	localparam longint KNEE_OUTER  = (19 * ONE_Q) / 8;
	localparam longint KNEE_INNER  = ONE_Q;
	localparam longint BIAS_OUTER  = (27 * ONE_Q) / 32;
	localparam longint BIAS_MIDDLE = (5 * ONE_Q) / 8;
	localparam longint BIAS_INNER  = ONE_Q / 2;
	localparam int     SLOPE_FRAC  = 12;
	localparam int     REPORT_MAX  = 10;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         last;
	} act_result_t;

	act_result_t                expected_q[$];
	act_result_t                want;
	logic [MODE_W-1:0]          mode_q;
	logic                       clamp_q;
	logic [SLOPE_W-1:0]         slope_q;
	int                         errors = 0;

	// four-segment PLAN sigmoid, mirrored for negative arguments
	function automatic longint sigmoid_plan(input longint x);
		longint a;
		longint y;
		a = (x < 0) ? -x : x;
		if (a >= KNEE_FLAT) begin
			y = ONE_Q;
		end else if (a >= KNEE_OUTER) begin
			y = (a >> 5) + BIAS_OUTER;
		end else if (a >= KNEE_INNER) begin
			y = (a >> 3) + BIAS_MIDDLE;
		end else begin
			y = (a >> 2) + BIAS_INNER;
		end
		return (x < 0) ? ONE_Q - y : y;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] activate(
		input logic signed [DATA_WIDTH-1:0] x_in,
		input logic [MODE_W-1:0]            mode,
		input logic                         clamp,
		input logic [SLOPE_W-1:0]           slope
	);
		longint x;
		longint y;
		longint hi;
		longint lo;
		x = x_in;
		case (mode)
			MODE_RELU:    y = (x < 0) ? 0 : x;
			MODE_LEAKY:   y = (x < 0) ? ((x * longint'(slope)) >>> SLOPE_FRAC) : x;
			MODE_STEP:    y = (x >= 0) ? ONE_Q : 0;
			MODE_SIGMOID: y = sigmoid_plan(x);
			MODE_TANH:    y = 2 * sigmoid_plan(2 * x) - ONE_Q;
			MODE_SWISH:   y = (x * sigmoid_plan(x)) >>> FRAC_BITS;
			default:      y = x;
		endcase
		if (y > SAT_HI) y = SAT_HI;
		if (y < SAT_LO) y = SAT_LO;
		if (clamp) begin
			hi = (ONE_Q > SAT_HI) ? SAT_HI : ONE_Q;
			lo = (-ONE_Q < SAT_LO) ? SAT_LO : -ONE_Q;
			if (y > hi) y = hi;
			if (y < lo) y = lo;
		end
		return y[DATA_WIDTH-1:0];
	endfunction

	task automatic flag(input string msg);
		errors++;
		if (errors <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  = ACT_MODE_RST;
			clamp_q = CLAMP_RST;
			slope_q = LEAKY_SLOPE_RST;
			expected_q.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					flag($sformatf("activation %0d with no item outstanding", activation));
				end else begin
					want = expected_q.pop_front();
					if (activation !== want.value)
						flag($sformatf("activation: expected %0d, got %0d",
							want.value, activation));
					if (last_out !== want.last)
						flag($sformatf("last_out: expected %0b, got %0b",
							want.last, last_out));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACT_MODE:     mode_q  = cfg_wdata[MODE_W-1:0];
					CFG_CLAMP_ENABLE: clamp_q = cfg_wdata[0];
					CFG_LEAKY_SLOPE:  slope_q = cfg_wdata[SLOPE_W-1:0];
					default:          ;
				endcase
			end
			if (start && !busy) begin
				want.value = activate(sample, mode_q, clamp_q, slope_q);
				want.last  = last_in;
				expected_q.push_back(want);
			end
			pending <= expected_q.size();
			fail_count <= errors;
		end
	end

endmodule

/* tb/neural_activation_unit_test.sv */
// ----------------------------------------------------------------------------
// neural_activation_unit_test
// Drives the activation unit through every mode, clamp setting and slope
// extreme: a short directed pass over the sample extremes, then phases of
// random samples biased towards the sigmoid knees. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module neural_activation_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nau_pkg::*;

	localparam int FRAC_BITS     = 12;
	localparam int DATA_WIDTH    = 16;
	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 8;
	localparam int RANDOM_PHASES = 20;
	localparam int PHASE_ITEMS   = 100;
	localparam int CALM_FIRST    = 12;
	localparam int CALM_LAST     = 14;
	localparam int IDLE_PCT      = 22;
	localparam int DRAIN_MARGIN  = 2;
	localparam int TAIL_CYCLES   = 8;
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam int ONE_Q         = 1 << FRAC_BITS;

	// register index with nothing behind it, and the mode code left unused
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd7;

	localparam logic [DATA_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         start     = 1'b0;
	logic                         busy;
	logic signed [DATA_WIDTH-1:0] sample    = '0;
	logic                         last_in   = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = CFG_ACT_MODE;
	logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
	logic                         done;
	logic signed [DATA_WIDTH-1:0] activation;
	logic                         last_out;
	int                           fail_count;
	int                           pending;

	logic [MODE_W-1:0] directed_modes [8] = '{MODE_RELU, MODE_LEAKY, MODE_STEP,
		MODE_SIGMOID, MODE_TANH, MODE_SWISH, MODE_IDENTITY, MODE_SPARE};

	always #(CLK_HALF) clk = ~clk;

	neural_activation_unit #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.last_in    (last_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.activation (activation),
		.last_out   (last_out)
	);

	neural_activation_unit_checker #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) activation_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.last_in    (last_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.activation (activation),
		.last_out   (last_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Half the samples are fully random. The rest sit within a few LSBs of a
	// sigmoid knee (or of half a knee, where tanh doubles its argument) or
	// inside the curved part of the range, where the segments actually matter.
	function automatic logic [DATA_WIDTH-1:0] pick_sample();
		int roll;
		int base;
		roll = $urandom_range(99);
		if (roll < 50) return DATA_WIDTH'($urandom);
		if (roll < 80) begin
			case ($urandom_range(6))
				0:       base = 0;
				1:       base = ONE_Q / 2;
				2:       base = ONE_Q;
				3:       base = (19 * ONE_Q) / 16;
				4:       base = (19 * ONE_Q) / 8;
				5:       base = (5 * ONE_Q) / 2;
				default: base = 5 * ONE_Q;
			endcase
			base = base + $urandom_range(6) - 3;
		end else begin
			base = $urandom_range(6 * ONE_Q);
		end
		if ($urandom_range(1)) base = -base;
		return base[DATA_WIDTH-1:0];
	endfunction

	// Offer one item and hold it until the block takes it; idle beforehand
	// now and then unless the phase is a calm one.
	task automatic send_item(input logic [DATA_WIDTH-1:0] s, input logic l,
		input bit calm);
		int gap;
		gap = (!calm && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 2) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		sample  <= s;
		last_in <= l;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every item in flight has produced its result.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_MARGIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [MODE_W-1:0]     mode;
		logic [SLOPE_W-1:0]    slope;
		logic                  clamp;
		logic [CFG_DATA_W-1:0] junk;
		bit                    calm;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass: both sample extremes and the zero/minus-one boundary in
		// every mode, spare code included; clamp follows the mode's low bit.
		// The write to the empty index just before the spare mode must change
		// nothing.
		foreach (directed_modes[i]) begin
			if (directed_modes[i] == MODE_SPARE) write_reg(CFG_UNUSED, '1);
			write_reg(CFG_ACT_MODE, CFG_DATA_W'(directed_modes[i]));
			write_reg(CFG_CLAMP_ENABLE, CFG_DATA_W'(directed_modes[i][0]));
			send_item(SAMPLE_MIN, 1'b0, 1'b0);
			send_item(SAMPLE_MAX, 1'b1, 1'b0);
			send_item(directed_modes[i][0] ? '1 : '0, directed_modes[i][1], 1'b0);
			settle();
		end

		// Random phases: leaky relu at both slope extremes first, then each mode
		// in turn, then random settings. Upper bits of the register writes carry
		// junk that the block must ignore.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			junk = CFG_DATA_W'($urandom);
			if (p < 2) begin
				mode = MODE_LEAKY;
			end else if (p < 10) begin
				mode = MODE_W'(p - 2);
			end else begin
				mode = MODE_W'($urandom_range(7));
			end
			slope = (p == 0) ? '0 : (p == 1) ? '1 : SLOPE_W'($urandom);
			clamp = (p < 2) ? p[0] : 1'($urandom_range(1));
			write_reg(CFG_ACT_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
			write_reg(CFG_CLAMP_ENABLE, {junk[CFG_DATA_W-1:1], clamp});
			write_reg(CFG_LEAKY_SLOPE, CFG_DATA_W'(slope));
			if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, ~junk);
			calm = (p >= CALM_FIRST && p <= CALM_LAST);
			repeat (PHASE_ITEMS) send_item(pick_sample(), 1'($urandom_range(1)), calm);
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS neural_activation_unit");
		end else begin
			$display("FAIL neural_activation_unit");
		end
		$finish;
	end

	// hang guard: a lost result leaves settle waiting forever
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL neural_activation_unit");
		$finish;
	end

endmodule

/* neural_activation_unit.f */
design/nau_pkg.sv
design/nau_sigmoid.sv
design/nau_post.sv
design/neural_activation_unit.sv
design/nau_checker.sv
tb/neural_activation_unit_checker.sv
tb/neural_activation_unit_test.sv
